[rtl/ple_pkg.sv]
// ple_pkg: shared types and constants for the positional list engine
// holds command/result beat structs, opcode, status and state enums
// no dependencies
package ple_pkg;

  localparam int CAPACITY    = 32;
  localparam int MAX_RESULTS = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int LEN_W       = 6;
  localparam int POS_W       = 8;
  localparam int DATA_W      = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_APPEND = 2'd1,
    OP_REMOVE = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STATUS_DONE  = 3'd0,
    STATUS_FULL  = 3'd1,
    STATUS_NONE  = 3'd2,
    STATUS_ELEM  = 3'd3,
    STATUS_EMPTY = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_LIST,
    S_DRAIN,
    S_PUT
  } state_e;

  typedef struct packed {
    op_e                      opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] element;
    logic                     last;
    logic [LEN_W-1:0]         length;
  } res_t;

endpackage

[rtl/positional_list_engine.sv]
// positional_list_engine: bounded ordered list of signed 32-bit values
// element store is a single-port-write synchronous memory with a registered read
// depends on ple_pkg
//
// A command beat is taken when start_i is high and busy_o is low. Every command
// gives its result beats on res_o, each marked by res_valid_o for one cycle;
// the receiver cannot stall them, and a listing streams one beat per cycle with
// last set on the final one. Insert and remove move the elements behind the
// target index through the element memory one per cycle (read one cycle, write
// back the next); an insert then writes the new value in S_PUT, and a remove
// answers in S_DRAIN. An insert at the tail goes straight to S_PUT, and a
// remove at the tail, a rejected command or a listing of an empty list is
// answered at once. The memory's single write port sets the pace of the moves.
module positional_list_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ple_pkg::cmd_t cmd_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output ple_pkg::res_t res_o
);
  import ple_pkg::*;

  logic signed [DATA_W-1:0] mem_q [CAPACITY];
  logic signed [DATA_W-1:0] rdata_q;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [IDX_W-1:0] ptr_q, ptr_d, end_q, end_d, pos_q, pos_d;
  logic [IDX_W-1:0] pend_addr_q, pend_addr_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic [LEN_W-1:0] count_q, count_d;
  logic pend_q, pend_d, pend_last_q, pend_last_d;
  logic res_valid_q, res_valid_d;
  res_t res_q, res_d;

  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;

  logic             accept, is_full, rem_ok, rem_tail, walk_done;
  logic [POS_W-1:0] count_ext, ins_pos, pos_inc;
  logic [LEN_W-1:0] cnt_dec, cnt_inc;
  logic [IDX_W-1:0] list_end;

  assign busy_o      = (state_q != S_IDLE);
  assign accept      = start_i && !busy_o;
  assign count_ext   = POS_W'(count_q);
  assign cnt_dec     = count_q - LEN_W'(1);
  assign cnt_inc     = count_q + LEN_W'(1);
  assign is_full     = (count_q >= LEN_W'(CAPACITY));
  assign rem_ok      = (cmd_i.position < count_ext);
  assign rem_tail    = (cmd_i.position == POS_W'(cnt_dec));
  assign pos_inc     = cmd_i.position + POS_W'(1);
  assign walk_done   = (ptr_q == end_q);
  assign list_end    = (count_q > LEN_W'(MAX_RESULTS)) ? IDX_W'(MAX_RESULTS - 1)
                                                       : cnt_dec[IDX_W-1:0];
  // append lands at count, an insert at min(position, count)
  assign ins_pos     = (cmd_i.opcode == OP_APPEND || cmd_i.position > count_ext)
                       ? count_ext : cmd_i.position;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_i.opcode) inside
            OP_INSERT, OP_APPEND: begin
              if (!is_full) begin
                state_d = (ins_pos == count_ext) ? S_PUT : S_SHIFT_UP;
              end
            end
            OP_REMOVE: begin
              if (rem_ok && !rem_tail) state_d = S_SHIFT_DN;
            end
            default: begin
              if (count_q != '0) state_d = S_LIST;
            end
          endcase
        end
      end
      S_SHIFT_UP, S_SHIFT_DN, S_LIST: begin
        if (walk_done) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = (op_q == OP_INSERT || op_q == OP_APPEND) ? S_PUT : S_IDLE;
      end
      S_PUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_d        = op_q;
    val_d       = val_q;
    pos_d       = pos_q;
    ptr_d       = ptr_q;
    end_d       = end_q;
    count_d     = count_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    pend_last_d = 1'b0;
    res_valid_d = 1'b0;
    res_d       = '0;
    mem_we      = 1'b0;
    mem_waddr   = pend_addr_q;
    mem_wdata   = rdata_q;

    // second half of a walk step: write back or emit what was read last cycle
    if (pend_q) begin
      if (op_q == OP_LIST) begin
        res_valid_d   = 1'b1;
        res_d.status  = STATUS_ELEM;
        res_d.element = rdata_q;
        res_d.last    = pend_last_q;
        res_d.length  = count_q;
      end else begin
        mem_we = 1'b1;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = cmd_i.opcode;
          val_d = cmd_i.value;
          res_d.last   = 1'b1;
          res_d.length = count_q;
          unique case (cmd_i.opcode) inside
            OP_INSERT, OP_APPEND: begin
              if (is_full) begin
                res_valid_d  = 1'b1;
                res_d.status = STATUS_FULL;
              end else begin
                pos_d = ins_pos[IDX_W-1:0];
                ptr_d = cnt_dec[IDX_W-1:0];
                end_d = ins_pos[IDX_W-1:0];
              end
            end
            OP_REMOVE: begin
              if (!rem_ok) begin
                res_valid_d  = 1'b1;
                res_d.status = STATUS_NONE;
              end else if (rem_tail) begin
                count_d      = cnt_dec;
                res_valid_d  = 1'b1;
                res_d.status = STATUS_DONE;
                res_d.length = cnt_dec;
              end else begin
                ptr_d = pos_inc[IDX_W-1:0];
                end_d = cnt_dec[IDX_W-1:0];
              end
            end
            default: begin
              if (count_q == '0) begin
                res_valid_d  = 1'b1;
                res_d.status = STATUS_EMPTY;
              end else begin
                ptr_d = '0;
                end_d = list_end;
              end
            end
          endcase
        end
      end
      S_SHIFT_UP: begin
        pend_d      = 1'b1;
        pend_addr_d = ptr_q + IDX_W'(1);
        if (!walk_done) ptr_d = ptr_q - IDX_W'(1);
      end
      S_SHIFT_DN: begin
        pend_d      = 1'b1;
        pend_addr_d = ptr_q - IDX_W'(1);
        if (!walk_done) ptr_d = ptr_q + IDX_W'(1);
      end
      S_LIST: begin
        pend_d      = 1'b1;
        pend_last_d = walk_done;
        if (!walk_done) ptr_d = ptr_q + IDX_W'(1);
      end
      S_DRAIN: begin
        if (op_q == OP_REMOVE) begin
          count_d      = cnt_dec;
          res_valid_d  = 1'b1;
          res_d.status = STATUS_DONE;
          res_d.last   = 1'b1;
          res_d.length = cnt_dec;
        end
      end
      S_PUT: begin
        mem_we       = 1'b1;
        mem_waddr    = pos_q;
        mem_wdata    = val_q;
        count_d      = cnt_inc;
        res_valid_d  = 1'b1;
        res_d.status = STATUS_DONE;
        res_d.last   = 1'b1;
        res_d.length = cnt_inc;
      end
      default: ;
    endcase
  end

  // element memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rdata_q <= mem_q[ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    val_q       <= val_d;
    pos_q       <= pos_d;
    ptr_q       <= ptr_d;
    end_q       <= end_d;
    pend_addr_q <= pend_addr_d;
    pend_last_q <= pend_last_d;
    res_q       <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[rtl/ple_checker.sv]
// ple_checker: port-level assertions for positional_list_engine
// bound to positional_list_engine below; depends on ple_pkg
module ple_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input ple_pkg::cmd_t cmd_i,
  input logic          busy_o,
  input logic          res_valid_o,
  input ple_pkg::res_t res_o
);
  import ple_pkg::*;

  // a taken command either works on or answers at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || res_valid_o)
    else $error("accepted command produced no activity");

  // only listed-element beats may be non-final
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != STATUS_ELEM |-> res_o.last)
    else $error("non-element beat without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != STATUS_ELEM |-> res_o.element == '0)
    else $error("element nonzero on status beat");

  // a listing streams without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |=> res_valid_o && res_o.status == STATUS_ELEM)
    else $error("gap in listing stream");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.length <= LEN_W'(CAPACITY))
    else $error("length beyond capacity");

endmodule

bind positional_list_engine ple_checker u_ple_checker (.*);

[bench/ple_tb_pkg.sv]
// ple_tb_pkg: list shadow and result scoreboard for the positional list engine bench
// mirrors the ordered list, queues the expected result beats and compares them
// depends on ple_pkg
package ple_tb_pkg;

  import ple_pkg::*;

  class list_shadow;

    logic signed [DATA_W-1:0] held[$];
    res_t                     due_beats[$];
    int unsigned              failures;

    function new();
      failures = 0;
    endfunction

    function int count();
      return held.size();
    endfunction

    function int pending();
      return due_beats.size();
    endfunction

    // apply one accepted command to the mirror and queue its result beats
    function void note_command(cmd_t cmd);
      res_t        beat;
      int unsigned pos;
      int          n;
      beat         = '0;
      beat.last    = 1'b1;
      beat.element = '0;
      pos          = cmd.position;
      case (cmd.opcode)
        OP_INSERT, OP_APPEND: begin
          if (held.size() >= CAPACITY) begin
            beat.status = STATUS_FULL;
          end else begin
            // appends and out-of-range inserts land at the tail
            if (cmd.opcode == OP_APPEND || pos > held.size()) pos = held.size();
            held.insert(int'(pos), cmd.value);
            beat.status = STATUS_DONE;
          end
        end
        OP_REMOVE: begin
          if (pos >= held.size()) begin
            beat.status = STATUS_NONE;
          end else begin
            held.delete(int'(pos));
            beat.status = STATUS_DONE;
          end
        end
        default: begin
          if (held.size() == 0) begin
            beat.status = STATUS_EMPTY;
          end else begin
            n = (held.size() > MAX_RESULTS) ? MAX_RESULTS : held.size();
            for (int i = 0; i < n; i++) begin
              beat.status  = STATUS_ELEM;
              beat.element = held[i];
              beat.last    = (i == n - 1);
              beat.length  = LEN_W'(held.size());
              due_beats.push_back(beat);
            end
            return;
          end
        end
      endcase
      beat.length = LEN_W'(held.size());
      due_beats.push_back(beat);
    endfunction

    function void check_beat(res_t got);
      res_t want;
      if (due_beats.size() == 0) begin
        $error("result beat with nothing expected: status %0d element %0d",
               got.status, got.element);
        failures++;
        return;
      end
      want = due_beats.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        failures++;
      end
      if (got.element !== want.element) begin
        $error("element: expected %0d, actual %0d", want.element, got.element);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        failures++;
      end
      if (got.length !== want.length) begin
        $error("length: expected %0d, actual %0d", want.length, got.length);
        failures++;
      end
    endfunction

  endclass

endpackage

[bench/positional_list_engine_tb.sv]
// positional_list_engine_tb: top-level bench for the positional list engine
// drives directed and random list commands with random idling, checks every result beat
// depends on ple_pkg, ple_tb_pkg and the positional_list_engine rtl
module positional_list_engine_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;
  import ple_tb_pkg::*;

  localparam int RANDOM_ITEMS = 110;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_LIMIT  = 5000;

  typedef enum int {
    MODE_GROW,
    MODE_SHRINK,
    MODE_MIXED
  } mix_e;

  logic clk_i;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  cmd_t cmd_i   = '0;
  logic busy_o;
  logic res_valid_o;
  res_t res_o;

  list_shadow shadow = new();
  bit         steady = 1'b0;
  int         issued = 0;

  positional_list_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o === 1'b1) shadow.check_beat(res_o);
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3:       return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_insert_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return POS_W'($urandom_range(0, shadow.count()));
    if (r < 75) return POS_W'(shadow.count());
    if (r < 85) return '0;
    return POS_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [POS_W-1:0] pick_remove_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && shadow.count() > 0) return POS_W'($urandom_range(0, shadow.count() - 1));
    if (r < 80) return POS_W'(shadow.count());
    return POS_W'($urandom_range(0, 255));
  endfunction

  // start stays high across back-to-back beats, so it is only lowered for a gap
  task automatic send_command(input op_e op, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val);
    cmd_t cmd;
    int   gap;
    gap          = steady ? 0 : pick_gap();
    cmd.opcode   = op;
    cmd.position = pos;
    cmd.value    = val;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i   <= cmd;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    shadow.note_command(cmd_i);
    issued++;
  endtask

  task automatic send_random(input mix_e mode);
    int  r;
    op_e op;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW:   op = (r < 45) ? OP_INSERT : (r < 75) ? OP_APPEND :
                        (r < 88) ? OP_REMOVE : OP_LIST;
      MODE_SHRINK: op = (r < 65) ? OP_REMOVE : (r < 80) ? OP_INSERT :
                        (r < 88) ? OP_APPEND : OP_LIST;
      default:     op = op_e'(r % 4);
    endcase
    if (op == OP_REMOVE) send_command(op, pick_remove_pos(), pick_value());
    else send_command(op, pick_insert_pos(), pick_value());
  endtask

  initial begin
    int   target;
    int   waited;
    mix_e mode;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, clamping, head/middle/tail edits, extreme values
    send_command(OP_LIST,   8'd0,   32'sd0);
    send_command(OP_REMOVE, 8'd0,   32'sd0);
    send_command(OP_REMOVE, 8'd255, 32'sd0);
    send_command(OP_INSERT, 8'd255, 32'sh7fff_ffff);
    send_command(OP_INSERT, 8'd0,   32'sh8000_0000);
    send_command(OP_APPEND, 8'd255, -32'sd1);
    send_command(OP_APPEND, 8'd0,   32'sd0);
    send_command(OP_INSERT, 8'd2,   32'sh5a5a_5a5a);
    send_command(OP_INSERT, 8'd5,   32'sha5a5_a5a5);
    send_command(OP_LIST,   8'd170, -32'sd1);
    send_command(OP_REMOVE, 8'd6,   32'sd0);
    send_command(OP_REMOVE, 8'd255, -32'sd1);
    send_command(OP_REMOVE, 8'd2,   32'sd0);
    send_command(OP_REMOVE, 8'd0,   32'sd0);
    send_command(OP_REMOVE, 8'd2,   32'sd0);
    send_command(OP_LIST,   8'd85,  32'sd0);
    send_command(OP_REMOVE, 8'd0,   32'sd0);
    send_command(OP_REMOVE, 8'd0,   32'sd0);
    send_command(OP_LIST,   8'd0,   32'sd0);
    send_command(OP_APPEND, 8'd0,   32'sd1);

    target = issued + RANDOM_ITEMS;

    // fill to capacity with random content, then hit the full list
    steady = 1'b1;
    while (shadow.count() < CAPACITY) begin
      if ($urandom_range(0, 2) == 0) send_command(OP_APPEND, pick_insert_pos(), pick_value());
      else send_command(OP_INSERT, pick_insert_pos(), pick_value());
      if ($urandom_range(0, 7) == 0) steady = ~steady;
    end
    send_command(OP_INSERT, 8'd0,   pick_value());
    send_command(OP_APPEND, 8'd255, pick_value());
    send_command(OP_LIST,   8'd0,   32'sd0);

    while (issued < target) begin
      mode   = mix_e'($urandom_range(0, 2));
      steady = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(8, 20)) begin
        if (issued < target) send_random(mode);
      end
    end
    start_i <= 1'b0;

    waited = 0;
    while (shadow.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);
    if (shadow.pending() != 0) begin
      $error("%0d expected result beats never arrived", shadow.pending());
      shadow.failures++;
    end

    if (shadow.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
